[src/iopj_pkg.sv]
// Shared widths, types and state codes of the interval overlap pair join.
package iopj_pkg;

    localparam int WINDOW_DEPTH = 32;
    localparam int COORD_WIDTH  = 32;
    localparam int ID_WIDTH     = 16;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic [ID_WIDTH-1:0]           id_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MATCH,
        ST_EMIT
    } state_t;

    // Broadcast from the controller to every cell of one window row.
    typedef struct packed {
        logic   match;
        logic   own;
        logic   take;
        logic   clear;
        logic   pick;
        coord_t lo;
        coord_t hi;
        id_t    id;
    } cmd_t;

    // Handed from each cell to its upper neighbor.
    typedef struct packed {
        logic free;
        logic hit;
        logic hit2;
        logic any;
        id_t  id;
    } link_t;

endpackage

[src/interval_overlap_pair_join.sv]
// Top level of the interval overlap pair join: controller, two window rows, output register.
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------------
//  in      | in_valid / in_stall   | y_min, y_max, edge_id, from_second_set, end_of_run
//  out     | out_valid / out_stall | first_set_id, second_set_id, window_overflow,
//          |                       | last_of_run
//
// An input word is accepted in the idle state and compared against the window in the
// match state; each result word it causes is then emitted in turn from the emit state.
// Results leave through a single output register; a stalled output holds its word
// and freezes result emission, and a new input is taken once the last result is loaded.
// Reset clears slot occupancy and pending pair flags at once; no clearing pass.
module interval_overlap_pair_join (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  iopj_pkg::coord_t y_min,
    input  iopj_pkg::coord_t y_max,
    input  iopj_pkg::id_t    edge_id,
    input  logic             from_second_set,
    input  logic             end_of_run,
    output logic             out_valid,
    input  logic             out_stall,
    output iopj_pkg::id_t    first_set_id,
    output iopj_pkg::id_t    second_set_id,
    output logic             window_overflow,
    output logic             last_of_run
);
    import iopj_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   ovf_pend_reg;
    logic   ovf_pend_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    coord_t lo_reg;
    coord_t hi_reg;
    id_t    id_reg;
    logic   second_reg;
    logic   eor_reg;

    id_t    first_id_reg;
    id_t    first_id_next;
    id_t    second_id_reg;
    id_t    second_id_next;
    logic   ovf_reg;
    logic   ovf_next;
    logic   last_reg;
    logic   last_next;

    cmd_t   cmd_first;
    cmd_t   cmd_second;
    link_t  tail_first;
    link_t  tail_second;
    link_t  own_tail;
    link_t  oth_tail;

    logic   accept;
    logic   full;
    logic   pop;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);

    assign own_tail = second_reg ? tail_second : tail_first;
    assign oth_tail = second_reg ? tail_first : tail_second;
    assign full     = !own_tail.free;
    assign pop      = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        cmd_first.match  = (state_reg == ST_MATCH);
        cmd_first.own    = !second_reg;
        cmd_first.take   = !full;
        cmd_first.clear  = eor_reg;
        cmd_first.pick   = pop && !ovf_pend_reg;
        cmd_first.lo     = lo_reg;
        cmd_first.hi     = hi_reg;
        cmd_first.id     = id_reg;
        cmd_second       = cmd_first;
        cmd_second.own   = second_reg;
    end

    iopj_row u_first_row (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_first),
        .tail  (tail_first)
    );

    iopj_row u_second_row (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_second),
        .tail  (tail_second)
    );

    always_comb
    begin
        state_next     = state_reg;
        ovf_pend_next  = ovf_pend_reg;
        out_valid_next = out_valid_reg && out_stall;
        first_id_next  = first_id_reg;
        second_id_next = second_id_reg;
        ovf_next       = ovf_reg;
        last_next      = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MATCH;
                end
            end
            ST_MATCH:
            begin
                if (full)
                begin
                    ovf_pend_next = 1'b1;
                    state_next    = ST_EMIT;
                end
                else if (oth_tail.any)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (pop)
                begin
                    out_valid_next = 1'b1;
                    if (ovf_pend_reg)
                    begin
                        first_id_next  = '0;
                        second_id_next = '0;
                        ovf_next       = 1'b1;
                        last_next      = 1'b1;
                        ovf_pend_next  = 1'b0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        first_id_next  = second_reg ? oth_tail.id : id_reg;
                        second_id_next = second_reg ? id_reg : oth_tail.id;
                        ovf_next       = 1'b0;
                        last_next      = !oth_tail.hit2;
                        if (!oth_tail.hit2)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ovf_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ovf_pend_reg  <= ovf_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lo_reg     <= y_min;
            hi_reg     <= y_max;
            id_reg     <= edge_id;
            second_reg <= from_second_set;
            eor_reg    <= end_of_run;
        end
        first_id_reg  <= first_id_next;
        second_id_reg <= second_id_next;
        ovf_reg       <= ovf_next;
        last_reg      <= last_next;
    end

    assign out_valid       = out_valid_reg;
    assign first_set_id    = first_id_reg;
    assign second_set_id   = second_id_reg;
    assign window_overflow = ovf_reg;
    assign last_of_run     = last_reg;

    // overflow word is always the only and final result of its input
    a_ovf_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && window_overflow |-> last_of_run && first_set_id == '0
            && second_set_id == '0)
        else $error("overflow word malformed");

    a_accept_match: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_MATCH)
        else $error("accepted word not matched next cycle");

    // emission of pairs only while a pending pair remains in the other window
    a_emit_hit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EMIT && !ovf_pend_reg |-> oth_tail.hit)
        else $error("emit state without pending pair");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(first_set_id)
            && $stable(second_set_id) && $stable(last_of_run))
        else $error("stalled result word changed");

endmodule

[src/iopj_cell.sv]
// One window slot: stored interval, occupancy, pending pair flag and chain links.
module iopj_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  iopj_pkg::cmd_t  cmd,
    input  iopj_pkg::link_t link_in,
    output iopj_pkg::link_t link_out
);
    import iopj_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    logic   hit_reg;
    logic   hit_next;
    coord_t upper_reg;
    id_t    ident_reg;

    logic expire;
    logic live;
    logic write;
    logic sel;

    assign expire = valid_reg && (upper_reg < cmd.lo);
    assign live   = valid_reg && !expire;
    // take the lowest free slot: no lower cell has claimed one yet
    assign write  = cmd.match && cmd.own && !link_in.free && !live;
    // lowest pending pair goes out first
    assign sel    = hit_reg && !link_in.hit;

    always_comb
    begin
        valid_next = valid_reg;
        hit_next   = hit_reg;
        if (cmd.match)
        begin
            valid_next = live || write;
            hit_next   = !cmd.own && cmd.take && live;
            if (cmd.clear)
            begin
                valid_next = 1'b0;
            end
        end
        else if (cmd.pick && sel)
        begin
            hit_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            hit_reg   <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write)
        begin
            upper_reg <= cmd.hi;
            ident_reg <= cmd.id;
        end
    end

    assign link_out.free = link_in.free || !live;
    assign link_out.hit  = link_in.hit || hit_reg;
    assign link_out.hit2 = link_in.hit2 || (link_in.hit && hit_reg);
    assign link_out.any  = link_in.any || live;
    assign link_out.id   = link_in.id | (sel ? ident_reg : '0);

endmodule

[src/iopj_row.sv]
// One set's window: a chain of slot cells from slot zero upward.
module iopj_row (
    input  logic           clk,
    input  logic           rst_n,
    input  iopj_pkg::cmd_t  cmd,
    output iopj_pkg::link_t tail
);
    import iopj_pkg::*;

    link_t chain [WINDOW_DEPTH+1];

    assign chain[0] = '0;

    for (genvar i = 0; i < WINDOW_DEPTH; i++)
    begin : g_cell
        iopj_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .link_in  (chain[i]),
            .link_out (chain[i+1])
        );
    end

    assign tail = chain[WINDOW_DEPTH];

endmodule

[tb/interval_overlap_pair_join_test.sv]
// Self-checking testbench for the interval overlap pair join: pair prediction and random traffic.
module interval_overlap_pair_join_test;
    import iopj_pkg::*;

    localparam int     QUIET_LIMIT  = 2000;
    localparam int     RANDOM_ITEMS = 360;
    localparam int     SETTLE       = 64;
    localparam int     REPORT_MAX   = 10;
    localparam bit     FIRST_SET    = 1'b0;
    localparam bit     SECOND_SET   = 1'b1;
    localparam coord_t C_MIN        = 32'sh8000_0000;
    localparam coord_t C_MAX        = 32'sh7fff_ffff;

    class pair_scoreboard;
        typedef struct packed {
            id_t  first_id;
            id_t  second_id;
            logic overflow;
            logic last;
        } pair_word_t;

        coord_t     upper[2][WINDOW_DEPTH];
        id_t        ident[2][WINDOW_DEPTH];
        bit         live[2][WINDOW_DEPTH];
        pair_word_t due_pairs[$];
        int         mismatch_count;

        function new();
            foreach (live[s, i])
                live[s][i] = 1'b0;
            mismatch_count = 0;
        endfunction

        function void note_interval(coord_t lo, coord_t hi, id_t id, bit second, bit eor);
            int         own;
            int         other;
            int         slot;
            int         hits[$];
            pair_word_t w;
            own   = int'(second);
            other = int'(!second);
            slot  = -1;
            // drop every stored interval that ends below the new lower bound
            foreach (live[s, i])
                if (live[s][i] && upper[s][i] < lo)
                    live[s][i] = 1'b0;
            for (int i = WINDOW_DEPTH - 1; i >= 0; i--)
                if (!live[own][i])
                    slot = i;
            if (slot < 0)
            begin
                w.first_id  = '0;
                w.second_id = '0;
                w.overflow  = 1'b1;
                w.last      = 1'b1;
                due_pairs.push_back(w);
            end
            else
            begin
                for (int i = 0; i < WINDOW_DEPTH; i++)
                    if (live[other][i] && upper[other][i] >= lo)
                        hits.push_back(i);
                foreach (hits[k])
                begin
                    w.first_id  = second ? ident[other][hits[k]] : id;
                    w.second_id = second ? id : ident[other][hits[k]];
                    w.overflow  = 1'b0;
                    w.last      = (k == hits.size() - 1);
                    due_pairs.push_back(w);
                end
                upper[own][slot] = hi;
                ident[own][slot] = id;
                live[own][slot]  = 1'b1;
            end
            if (eor)
                foreach (live[s, i])
                    live[s][i] = 1'b0;
        endfunction

        function void check_pair(id_t first_id, id_t second_id, logic overflow, logic last);
            pair_word_t want;
            if (due_pairs.size() == 0)
            begin
                if (mismatch_count < REPORT_MAX)
                    $display("unexpected word: first %h second %h overflow %b last %b",
                             first_id, second_id, overflow, last);
                mismatch_count++;
                return;
            end
            want = due_pairs.pop_front();
            if (first_id !== want.first_id || second_id !== want.second_id ||
                overflow !== want.overflow || last !== want.last)
            begin
                if (mismatch_count < REPORT_MAX)
                begin
                    $display("word mismatch: expected first %h second %h overflow %b last %b",
                             want.first_id, want.second_id, want.overflow, want.last);
                    $display("               got      first %h second %h overflow %b last %b",
                             first_id, second_id, overflow, last);
                end
                mismatch_count++;
            end
        endfunction

        function int outstanding();
            return due_pairs.size();
        endfunction
    endclass

    logic   clk = 1'b0;
    logic   rst_n;
    logic   in_valid;
    logic   in_stall;
    coord_t y_min;
    coord_t y_max;
    id_t    edge_id;
    logic   from_second_set;
    logic   end_of_run;
    logic   out_valid;
    logic   out_stall;
    id_t    first_set_id;
    id_t    second_set_id;
    logic   window_overflow;
    logic   last_of_run;

    pair_scoreboard sb = new();
    int             items_sent  = 0;
    int             quiet_cycles = 0;
    bit             in_calm     = 1'b0;
    bit             out_calm    = 1'b0;

    interval_overlap_pair_join dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .y_min           (y_min),
        .y_max           (y_max),
        .edge_id         (edge_id),
        .from_second_set (from_second_set),
        .end_of_run      (end_of_run),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .first_set_id    (first_set_id),
        .second_set_id   (second_set_id),
        .window_overflow (window_overflow),
        .last_of_run     (last_of_run)
    );

    always #10 clk = ~clk;

    function automatic coord_t clamp_coord(longint v);
        if (v > 64'sd2147483647)
            return C_MAX;
        if (v < -64'sd2147483648)
            return C_MIN;
        return coord_t'(v);
    endfunction

    task automatic send_interval(coord_t lo, coord_t hi, id_t id, bit second, bit eor);
        int gap;
        gap = in_calm ? 0 : $urandom_range(16, 0);
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        y_min           = lo;
        y_max           = hi;
        edge_id         = id;
        from_second_set = second;
        end_of_run      = eor;
        in_valid        = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_interval(lo, hi, id, second, eor);
        items_sent++;
    endtask

    // Fill one window past its depth, then sometimes let the other set pair with all of it.
    task automatic send_crowd();
        int     fill;
        int     tail;
        bit     crowd_set;
        coord_t lo;
        fill      = WINDOW_DEPTH + $urandom_range(2, 1);
        crowd_set = bit'($urandom_range(1, 0));
        lo        = coord_t'($urandom);
        tail      = $urandom_range(1, 0) ? 0 : $urandom_range(3, 1);
        for (int k = 0; k < fill; k++)
            send_interval(lo, C_MAX, id_t'($urandom), crowd_set, tail == 0 && k == fill - 1);
        for (int k = 0; k < tail; k++)
            send_interval(lo, clamp_coord(longint'(lo) + $urandom_range(50, 0)),
                          id_t'($urandom), !crowd_set, k == tail - 1);
    endtask

    task automatic send_sorted_run();
        int     len;
        int     step_max;
        int     width_max;
        longint lo_l;
        longint hi_l;
        len = $urandom_range(24, 1);
        if ($urandom_range(3, 0) == 0)
            lo_l = longint'(int'($urandom));
        else
            lo_l = longint'($urandom_range(400, 0)) - 200;
        case ($urandom_range(2, 0))
            0:       step_max = 0;
            1:       step_max = 3;
            default: step_max = 40;
        endcase
        case ($urandom_range(3, 0))
            0:       width_max = 0;
            1:       width_max = 12;
            2:       width_max = 150;
            default: width_max = 32'h7fff_ffff;
        endcase
        for (int k = 0; k < len; k++)
        begin
            lo_l += $urandom_range(step_max, 0);
            if ($urandom_range(15, 0) == 0)
                hi_l = lo_l - $urandom_range(20, 1);
            else
                hi_l = lo_l + $urandom_range(width_max, 0);
            send_interval(clamp_coord(lo_l), clamp_coord(hi_l), id_t'($urandom),
                          bit'($urandom_range(1, 0)),
                          k == len - 1 || $urandom_range(31, 0) == 0);
        end
    endtask

    task automatic send_noise_run();
        int len;
        len = $urandom_range(6, 1);
        for (int k = 0; k < len; k++)
            send_interval(coord_t'($urandom), coord_t'($urandom), id_t'($urandom),
                          bit'($urandom_range(1, 0)),
                          k == len - 1 || $urandom_range(3, 0) == 0);
    endtask

    // Result side: hold stall for a drawn number of cycles before each word.
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left != 0)
            begin
                out_stall = 1'b1;
                stall_left--;
            end
            else
                out_stall = 1'b0;
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                sb.check_pair(first_set_id, second_set_id, window_overflow, last_of_run);
                if ($urandom_range(31, 0) == 0)
                    out_calm = !out_calm;
                stall_left = out_calm ? 0 : $urandom_range(16, 0);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int random_start;
        int kind;
        bit crowd_done;
        rst_n           = 1'b0;
        in_valid        = 1'b0;
        y_min           = '0;
        y_max           = '0;
        edge_id         = '0;
        from_second_set = 1'b0;
        end_of_run      = 1'b0;
        crowd_done      = 1'b0;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        send_interval(C_MIN, C_MIN, 16'h0000, FIRST_SET, 1'b0);
        send_interval(C_MIN, C_MAX, 16'hffff, SECOND_SET, 1'b0);
        // expire the first word, keep the wide one
        send_interval(C_MIN + 1, 5, 16'h1234, FIRST_SET, 1'b0);
        // upper bound equal to the new lower bound still overlaps
        send_interval(5, 5, 16'h00ff, SECOND_SET, 1'b0);
        send_interval(6, 3, 16'hff00, FIRST_SET, 1'b0);
        // lower bound steps back
        send_interval(4, 10, 16'h0f0f, SECOND_SET, 1'b0);
        send_interval(C_MAX, C_MAX, 16'hf0f0, FIRST_SET, 1'b1);
        send_interval(0, 0, 16'haaaa, SECOND_SET, 1'b1);
        send_interval(-1, 0, 16'h5555, FIRST_SET, 1'b0);
        send_interval(-1, -1, 16'h3333, FIRST_SET, 1'b0);
        send_interval(0, 100, 16'hcccc, SECOND_SET, 1'b0);
        send_interval(0, 50, 16'h0001, FIRST_SET, 1'b0);
        send_interval(1, 1, 16'h0002, SECOND_SET, 1'b0);
        send_interval(2, 2, 16'h8000, SECOND_SET, 1'b0);
        send_interval(2, C_MAX, 16'h7fff, FIRST_SET, 1'b1);
        send_interval(C_MIN, C_MAX, 16'h0001, SECOND_SET, 1'b0);
        send_interval(C_MAX, C_MIN, 16'hfffe, FIRST_SET, 1'b1);

        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS)
        begin
            in_calm = ($urandom_range(3, 0) == 0);
            kind    = crowd_done ? $urandom_range(15, 0) : 0;
            crowd_done = 1'b1;
            if (kind == 0)
                send_crowd();
            else if (kind < 3)
                send_noise_run();
            else
                send_sorted_run();
        end
        @(negedge clk);
        in_valid = 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (sb.mismatch_count == 0 && sb.outstanding() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
